// ===== sv/wsf_pkg.sv =====
// shared types and constants of the section framer
`default_nettype none

package wsf_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic [WORD_W-1:0] MAGIC_RESET   = 32'h6d736100;
  localparam logic [WORD_W-1:0] VERSION_RESET = 32'h00000001;

  // configuration register indexes
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // result kinds
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_HDR   = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        section_id;
    logic [WORD_W-1:0] section_length;
    logic [WORD_W-1:0] payload_offset;
    logic [1:0]        status;
    logic              final_res;
  } result_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    logic              has_desc;
    logic [7:0]        id;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] off;
    logic              has_stat;
    status_t           status;
  } event_t;

endpackage

`default_nettype wire

// ===== sv/wsf_front.sv =====
// front end: header check, section framing and size decoding
`default_nettype none

module wsf_front import wsf_pkg::*; #(
  parameter int unsigned MAX_LEB_BYTES = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  input  wire logic              accept,
  input  wire item_t             item,
  output      logic              push,
  output      event_t            evt
);

  localparam logic [2:0] MaxGroups = 3'(MAX_LEB_BYTES);

  logic [WORD_W-1:0] expected_magic;
  logic [WORD_W-1:0] expected_version;

  phase_t            phase, phase_next;
  logic [2:0]        header_count;
  logic [WORD_W-1:0] header_word;
  logic              header_bad;
  logic [WORD_W-1:0] size_accum;
  logic [2:0]        group_count;
  logic [7:0]        current_id;
  logic [WORD_W-1:0] bytes_left;
  logic [WORD_W-1:0] byte_offset;
  status_t           error_code, error_code_next;

  logic [WORD_W-1:0] hdr_merged;
  logic              hdr_bad_now;
  logic [2:0]        hc_inc;
  logic [47:0]       leb_part;
  logic [5:0]        leb_shift;
  logic [WORD_W-1:0] size_merged;
  logic              size_end;
  logic [2:0]        gc_inc;
  logic              too_long;
  logic [WORD_W-1:0] left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAGIC) begin
        expected_magic <= cfg_data;
      end else begin
        expected_version <= cfg_data;
      end
    end
  end

  always_comb begin
    hdr_merged  = header_word | (WORD_W'(item.data_byte) << {header_count[1:0], 3'b000});
    hdr_bad_now = header_bad
                | ((header_count == 3'd3) && (hdr_merged != expected_magic))
                | ((header_count == 3'd7) && (hdr_merged != expected_version));
    hc_inc      = header_count + 3'd1;
    leb_shift   = 6'(group_count) * 6'd7;
    leb_part    = {41'b0, item.data_byte[6:0]} << leb_shift;
    size_merged = size_accum | leb_part[WORD_W-1:0];
    size_end    = !item.data_byte[7];
    gc_inc      = group_count + 3'd1;
    too_long    = !size_end && (gc_inc >= MaxGroups);
    left_dec    = bytes_left - WORD_W'(1);
  end

  // next phase
  always_comb begin
    unique case (phase)
      PH_HEADER: begin
        if (hdr_bad_now) phase_next = PH_ERROR;
        else if (hc_inc == 3'd0) phase_next = PH_ID;
        else phase_next = PH_HEADER;
      end
      PH_ID: phase_next = PH_SIZE;
      PH_SIZE: begin
        if (size_end) phase_next = (size_merged == '0) ? PH_ID : PH_PAYLOAD;
        else if (too_long) phase_next = PH_ERROR;
        else phase_next = PH_SIZE;
      end
      PH_PAYLOAD: phase_next = (left_dec == '0) ? PH_ID : PH_PAYLOAD;
      default: phase_next = PH_ERROR;
    endcase
  end

  // error code and queue entry
  always_comb begin
    error_code_next = error_code;
    if (phase == PH_HEADER && hdr_bad_now) error_code_next = ST_BAD_HDR;
    if (phase == PH_SIZE && too_long) error_code_next = ST_TOO_LONG;

    evt.has_desc = (phase == PH_SIZE) && size_end;
    evt.id       = current_id;
    evt.len      = size_merged;
    evt.off      = byte_offset + WORD_W'(1);
    evt.has_stat = item.last_byte;
    if (error_code_next != ST_OK) evt.status = error_code_next;
    else if (phase_next == PH_ID) evt.status = ST_OK;
    else evt.status = ST_TRUNCATED;
    push = accept && (evt.has_desc || evt.has_stat);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      header_word  <= '0;
      header_bad   <= 1'b0;
      size_accum   <= '0;
      group_count  <= '0;
      current_id   <= '0;
      bytes_left   <= '0;
      byte_offset  <= '0;
      error_code   <= ST_OK;
    end else if (accept) begin
      phase       <= phase_next;
      error_code  <= error_code_next;
      byte_offset <= byte_offset + WORD_W'(1);
      unique case (phase)
        PH_HEADER: begin
          header_word  <= (header_count[1:0] == 2'd3) ? '0 : hdr_merged;
          header_bad   <= hdr_bad_now;
          header_count <= hc_inc;
        end
        PH_ID: begin
          current_id  <= item.data_byte;
          size_accum  <= '0;
          group_count <= '0;
        end
        PH_SIZE: begin
          size_accum  <= size_merged;
          group_count <= gc_inc;
          if (size_end) bytes_left <= size_merged;
        end
        PH_PAYLOAD: bytes_left <= left_dec;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/wsf_queue.sv =====
// short event queue between front and back
`default_nettype none

module wsf_queue import wsf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire event_t wr_data,
  input  wire logic   pop,
  output      event_t head,
  output      logic   empty,
  output      logic   full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  event_t          entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CntW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      if (pop) rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop) count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/wsf_back.sv =====
// back end: splits queue entries into result requests behind an output register
`default_nettype none

module wsf_back import wsf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire event_t  head,
  input  wire logic    empty,
  output      logic    pop,
  output      logic    res_valid,
  input  wire logic    res_ready,
  output      result_t res_item
);

  logic    desc_sent;
  logic    load;
  logic    send_desc;
  result_t next_res;

  always_comb begin
    load      = (!res_valid || res_ready) && !empty;
    send_desc = head.has_desc && !desc_sent;
    pop       = load && !(send_desc && head.has_stat);
    if (send_desc) begin
      next_res = '{kind: KIND_DESC, section_id: head.id, section_length: head.len,
                   payload_offset: head.off, status: ST_OK, final_res: 1'b0};
    end else begin
      next_res = '{kind: KIND_STAT, section_id: '0, section_length: '0,
                   payload_offset: '0, status: head.status, final_res: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      desc_sent <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        desc_sent <= !pop;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_item <= next_res;
  end

endmodule

`default_nettype wire

// ===== sv/wasm_section_framer_top.sv =====
// top level of the module image section framer
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   byte     | byte_valid / byte_ready   | byte_item (data_byte, last_byte)
//   result   | res_valid / res_ready     | res_item (descriptor or status)
//   config   | cfg_we                    | cfg_index, cfg_data
//
// one byte per cycle while the event queue is not full: the front updates its framing state as each byte is accepted
// a byte that ends a size and is also the last byte makes two result requests,
// which the back end sends one after the other, the descriptor first
// byte_ready falls only when the event queue is full
// rst is synchronous and returns config registers to their reset values
`default_nettype none

module wasm_section_framer_top import wsf_pkg::*; #(
  parameter int unsigned MAX_LEB_BYTES = 7,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // input bytes
  input  wire logic              byte_valid,
  output      logic              byte_ready,
  input  wire item_t             byte_item,
  // result requests
  output      logic              res_valid,
  input  wire logic              res_ready,
  output      result_t           res_item,
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data
);

  logic   accept;
  logic   push;
  event_t evt;
  event_t head;
  logic   q_empty;
  logic   q_full;
  logic   pop;

  // a byte is taken whenever the queue has room for its results
  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  wsf_front #(
    .MAX_LEB_BYTES(MAX_LEB_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (byte_item),
    .push     (push),
    .evt      (evt)
  );

  // decouples byte intake from result delivery
  wsf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(evt),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  wsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
  );

endmodule

`default_nettype wire
